[src/bpa_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types and codes of the bitmap page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

  typedef enum logic [1:0] {
    FN_INIT  = 2'd0,
    FN_ALLOC = 2'd1,
    FN_FREE  = 2'd2,
    FN_QUERY = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOINIT  = 2'd1,
    ST_OOM     = 2'd2,
    ST_BADADDR = 2'd3
  } status_t;

  typedef struct packed {
    func_t       func;
    logic        aligned;
    logic [31:0] page;
  } cmd_t;

  localparam int WORD_BITS = 64;
  localparam int WORD_SHIFT = 6;

endpackage
`default_nettype wire

[src/bpa_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_front
// Request register: takes a request and classifies its address.
// ----------------------------------------------------------------------------
module bpa_front #(
  parameter int PAGE_BYTES = 4096
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  output logic              in_stall,
  input  wire  [1:0]        func,
  input  wire  [31:0]       address,
  output logic              cmd_valid,
  output bpa_pkg::cmd_t     cmd,
  input  wire               cmd_ready
);
  localparam int SHIFT = $clog2(PAGE_BYTES);

  assign in_stall = cmd_valid && !cmd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (!in_stall) begin
      cmd_valid <= in_valid;
    end
    if (!in_stall && in_valid) begin
      cmd.func    <= bpa_pkg::func_t'(func);
      cmd.aligned <= (address[SHIFT-1:0] == '0);
      cmd.page    <= address >> SHIFT;
    end
  end
endmodule
`default_nettype wire

[src/bpa_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_queue
// Two-entry request queue between the front and the back.
// ----------------------------------------------------------------------------
module bpa_queue (
  input  wire            clk,
  input  wire            rst,
  input  wire            push,
  input  bpa_pkg::cmd_t  push_cmd,
  output logic           push_ready,
  input  wire            pop,
  output logic           pop_valid,
  output bpa_pkg::cmd_t  pop_cmd
);
  bpa_pkg::cmd_t slots [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_cmd    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && push_ready) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop && pop_valid) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'((push && push_ready) ? 1 : 0) - 2'((pop && pop_valid) ? 1 : 0);
    end
    if (push && push_ready) begin
      slots[wr_ptr] <= push_cmd;
    end
  end
endmodule
`default_nettype wire

[src/bpa_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_back
// Bitmap store, counters and the sequencer that carries out each request.
// ----------------------------------------------------------------------------
module bpa_back #(
  parameter int MAX_PAGES  = 32768,
  parameter int PAGE_BYTES = 4096,
  parameter int RESV_PAGES = 512
) (
  input  wire            clk,
  input  wire            rst,
  input  wire            memory_bytes_we,
  input  wire  [31:0]    memory_bytes,
  input  wire            cmd_valid,
  input  bpa_pkg::cmd_t  cmd,
  output logic           cmd_pop,
  output logic           out_valid,
  input  wire            out_stall,
  output logic [31:0]    page_address,
  output logic [1:0]     status,
  output logic           page_free,
  output logic [15:0]    free_pages,
  output logic [15:0]    allocated_pages,
  output logic [27:0]    total_memory,
  output logic           initialized
);
  localparam int SHIFT = $clog2(PAGE_BYTES);
  localparam int WORDS = MAX_PAGES / bpa_pkg::WORD_BITS;
  localparam int WIW   = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int HW    = WIW + 1;
  localparam int PCW   = $clog2(MAX_PAGES + 1);
  localparam int NW    = 33 - SHIFT;
  localparam int XW    = (NW > PCW) ? NW : PCW;
  localparam int WB    = bpa_pkg::WORD_BITS;
  localparam int WS    = bpa_pkg::WORD_SHIFT;

  typedef enum logic [2:0] {S_IDLE, S_SWEEP, S_ACHK, S_CHK} state_t;

  state_t               state;
  logic [31:0]          mem_bytes;
  logic [PCW-1:0]       page_count;
  logic [PCW-1:0]       used_count;
  logic [PCW-1:0]       resv_lim;
  logic                 ready_flag;
  logic [HW-1:0]        hint;
  logic [WIW-1:0]       sweep_idx;
  bpa_pkg::cmd_t        cur;
  logic [WB-1:0]        mem [WORDS];
  logic [WB-1:0]        rdata;
  logic [WIW-1:0]       rd_addr;
  logic                 we;
  logic [WIW-1:0]       waddr;
  logic [WB-1:0]        wdata;
  logic                 zero_found;
  logic [WS-1:0]        zero_bit;
  logic [HW-1:0]        hint_inc;
  logic [NW-1:0]        n_raw;
  logic [XW-1:0]        n_x;
  logic [PCW-1:0]       pc_new;
  logic [PCW-1:0]       lim_new;
  logic [31:0]          alloc_page;
  logic [WIW-1:0]       cur_word;
  logic                 cur_bit;
  logic                 pop_ok;

  assign n_raw   = NW'(mem_bytes >> SHIFT) + NW'(|mem_bytes[SHIFT-1:0]);
  assign n_x     = XW'(n_raw);
  assign pc_new  = (n_x > XW'(MAX_PAGES)) ? PCW'(MAX_PAGES) : n_x[PCW-1:0];
  assign lim_new = (32'(RESV_PAGES) >= 32'(pc_new)) ? pc_new : PCW'(RESV_PAGES);

  assign hint_inc   = hint + HW'(1);
  assign alloc_page = {(32 - HW - WS)'(0), hint, zero_bit};
  assign cur_word   = cur.page[WIW+WS-1:WS];
  assign cur_bit    = rdata[cur.page[WS-1:0]];
  assign pop_ok     = (state == S_IDLE) && cmd_valid && !out_valid;
  assign cmd_pop    = pop_ok;

  always_comb begin
    zero_found = 1'b0;
    zero_bit   = '0;
    for (int b = WB - 1; b >= 0; b--) begin
      if (!rdata[b]) begin
        zero_found = 1'b1;
        zero_bit   = WS'(b);
      end
    end
  end

  always_comb begin
    case (state)
      S_IDLE:  rd_addr = (cmd.func == bpa_pkg::FN_ALLOC) ? hint[WIW-1:0] :
                         cmd.page[WIW+WS-1:WS];
      S_ACHK:  rd_addr = hint_inc[WIW-1:0];
      default: rd_addr = hint[WIW-1:0];
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = sweep_idx;
    wdata = '0;
    case (state)
      S_SWEEP: begin
        we = 1'b1;
        if (32'(sweep_idx) < 32'(resv_lim >> WS)) begin
          wdata = '1;
        end else if (32'(sweep_idx) == 32'(resv_lim >> WS)) begin
          wdata = (WB'(1) << resv_lim[WS-1:0]) - WB'(1);
        end
      end
      S_ACHK: begin
        waddr = hint[WIW-1:0];
        wdata = rdata | (WB'(1) << zero_bit);
        we    = (32'({hint, WS'(0)}) < 32'(page_count)) && zero_found &&
                (alloc_page < 32'(page_count));
      end
      S_CHK: begin
        waddr = cur_word;
        wdata = rdata & ~(WB'(1) << cur.page[WS-1:0]);
        we    = (cur.func == bpa_pkg::FN_FREE) && cur_bit;
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      mem_bytes  <= '0;
      page_count <= '0;
      used_count <= '0;
      resv_lim   <= '0;
      ready_flag <= 1'b0;
      hint       <= '0;
      sweep_idx  <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (memory_bytes_we) begin
        mem_bytes <= memory_bytes;
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (pop_ok) begin
            cur          <= cmd;
            page_address <= '0;
            page_free    <= 1'b0;
            status       <= bpa_pkg::ST_OK;
            if (cmd.func == bpa_pkg::FN_INIT) begin
              page_count <= pc_new;
              used_count <= lim_new;
              resv_lim   <= lim_new;
              hint       <= HW'(lim_new >> WS);
              ready_flag <= 1'b1;
              sweep_idx  <= '0;
              state      <= S_SWEEP;
            end else if (!ready_flag) begin
              status    <= bpa_pkg::ST_NOINIT;
              out_valid <= 1'b1;
            end else if (cmd.func == bpa_pkg::FN_ALLOC) begin
              state <= S_ACHK;
            end else if (!cmd.aligned || cmd.page >= 32'(page_count)) begin
              status    <= bpa_pkg::ST_BADADDR;
              out_valid <= 1'b1;
            end else begin
              state <= S_CHK;
            end
          end
        end
        S_SWEEP: begin
          sweep_idx <= sweep_idx + WIW'(1);
          if (sweep_idx == WIW'(WORDS - 1)) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        S_ACHK: begin
          if (32'({hint, WS'(0)}) >= 32'(page_count)) begin
            status    <= bpa_pkg::ST_OOM;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end else if (!zero_found) begin
            hint <= hint_inc;
          end else if (alloc_page >= 32'(page_count)) begin
            status    <= bpa_pkg::ST_OOM;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end else begin
            used_count   <= used_count + PCW'(1);
            page_address <= alloc_page << SHIFT;
            out_valid    <= 1'b1;
            state        <= S_IDLE;
          end
        end
        S_CHK: begin
          if (cur.func == bpa_pkg::FN_QUERY) begin
            page_free <= !cur_bit;
          end else if (cur_bit) begin
            if (used_count != '0) begin
              used_count <= used_count - PCW'(1);
            end
            if (HW'(cur_word) < hint) begin
              hint <= HW'(cur_word);
            end
          end
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign free_pages      = 16'(page_count - used_count);
  assign allocated_pages = 16'(used_count);
  assign total_memory    = 28'(32'(page_count) << SHIFT);
  assign initialized     = ready_flag;

`ifndef NO_ASSERTIONS
  a_used_le_count: assert property (@(posedge clk) disable iff (rst)
    used_count <= page_count) else $error("used count above page count");
  a_hint_range: assert property (@(posedge clk) disable iff (rst)
    32'(hint) <= 32'(WORDS)) else $error("search hint out of range");
  a_hold_state: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(used_count) && $stable(page_count))
    else $error("state changed while a result waits");
  a_noinit: assert property (@(posedge clk) disable iff (rst)
    out_valid && !ready_flag |-> status == bpa_pkg::ST_NOINIT)
    else $error("result before init not flagged");
`endif
endmodule
`default_nettype wire

[src/bitmap_page_allocator.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_page_allocator
// Page frame allocator keeping one used bit per page in a word store.
//
// Requests (func, address) enter on in_valid/in_stall; one result per request
// leaves on out_valid/out_stall. memory_bytes is written with memory_bytes_we
// and takes effect at the next init request.
// A request passes a front register and a two-entry queue, then the back
// sequencer. An allocate steps over each full 64-page word in turn, the
// search starting at the lowest word that may hold a free page. Init sweeps
// the whole store, one word per cycle. The back takes the next request
// once the result register is empty; while out_stall holds a result the
// front keeps accepting until the queue and the front register are full.
// Reset empties the pipe and leaves the block uninitialized: every request
// but init answers not initialized, so no store clearing runs at reset.
// ----------------------------------------------------------------------------
module bitmap_page_allocator #(
  parameter int MAX_PAGES  = 32768,
  parameter int PAGE_BYTES = 4096,
  parameter int RESV_PAGES = 512
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         memory_bytes_we,
  input  wire  [31:0] memory_bytes,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [1:0]  func,
  input  wire  [31:0] address,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [31:0] page_address,
  output logic [1:0]  status,
  output logic        page_free,
  output logic [15:0] free_pages,
  output logic [15:0] allocated_pages,
  output logic [27:0] total_memory,
  output logic        initialized
);
  logic          f_valid;
  bpa_pkg::cmd_t f_cmd;
  logic          q_ready;
  logic          q_valid;
  bpa_pkg::cmd_t q_cmd;
  logic          q_pop;

  bpa_front #(.PAGE_BYTES(PAGE_BYTES)) u_front (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .address(address),
    .cmd_valid(f_valid), .cmd(f_cmd), .cmd_ready(q_ready)
  );

  bpa_queue u_queue (
    .clk(clk), .rst(rst),
    .push(f_valid), .push_cmd(f_cmd), .push_ready(q_ready),
    .pop(q_pop), .pop_valid(q_valid), .pop_cmd(q_cmd)
  );

  bpa_back #(
    .MAX_PAGES(MAX_PAGES), .PAGE_BYTES(PAGE_BYTES), .RESV_PAGES(RESV_PAGES)
  ) u_back (
    .clk(clk), .rst(rst),
    .memory_bytes_we(memory_bytes_we), .memory_bytes(memory_bytes),
    .cmd_valid(q_valid), .cmd(q_cmd), .cmd_pop(q_pop),
    .out_valid(out_valid), .out_stall(out_stall),
    .page_address(page_address), .status(status), .page_free(page_free),
    .free_pages(free_pages), .allocated_pages(allocated_pages),
    .total_memory(total_memory), .initialized(initialized)
  );
endmodule
`default_nettype wire

[tb/tb_bitmap_page_allocator.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tb_bitmap_page_allocator
// Self-checking bench for the bitmap page allocator.
//
// Directed and random requests are driven with random bursts and gaps. The
// result side stalls on its own random pattern, with one long hold-off. A
// predictor inside the bench keeps its own page bitmap and counters, and each
// result is compared field by field with the oldest predicted result.
// ----------------------------------------------------------------------------
module tb_bitmap_page_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NPAGES    = 32768;
  localparam int PG_BYTES  = 4096;
  localparam int RSV_PAGES = 512;

  typedef struct {
    logic [31:0]      page_address;
    bpa_pkg::status_t status;
    logic             page_free;
    logic [15:0]      free_pages;
    logic [15:0]      allocated_pages;
    logic [27:0]      total_memory;
    logic             initialized;
  } alloc_result_t;

  logic        clk;
  logic        rst;
  logic        memory_bytes_we;
  logic [31:0] memory_bytes;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  func;
  logic [31:0] address;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] page_address;
  logic [1:0]  status;
  logic        page_free;
  logic [15:0] free_pages;
  logic [15:0] allocated_pages;
  logic [27:0] total_memory;
  logic        initialized;

  bitmap_page_allocator i_dut (
    .clk             (clk),
    .rst             (rst),
    .memory_bytes_we (memory_bytes_we),
    .memory_bytes    (memory_bytes),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .func            (func),
    .address         (address),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .page_address    (page_address),
    .status          (status),
    .page_free       (page_free),
    .free_pages      (free_pages),
    .allocated_pages (allocated_pages),
    .total_memory    (total_memory),
    .initialized     (initialized)
  );

  // allocator shadow state
  bit [NPAGES-1:0] page_used;
  int unsigned     used_pages;
  int unsigned     page_total;
  bit              is_ready;
  logic [31:0]     mem_size;

  alloc_result_t pending_results[$];
  bit            failed;
  bit            steady_send;
  bit            steady_recv;
  bit            hold_req;
  int            burst_left;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("tb: failure");
    $finish;
  end

  function automatic alloc_result_t predict_alloc(bpa_pkg::func_t f, logic [31:0] a);
    alloc_result_t r;
    longint unsigned n;
    int unsigned p;
    r.page_address = '0;
    r.status = bpa_pkg::ST_OK;
    r.page_free = 1'b0;
    if (f == bpa_pkg::FN_INIT) begin
      n = (longint'(mem_size) + PG_BYTES - 1) / PG_BYTES;
      if (n > NPAGES) n = NPAGES;
      page_total = 32'(n);
      page_used = '0;
      used_pages = 0;
      for (int i = 0; i < RSV_PAGES && i < page_total; i++) begin
        page_used[i] = 1'b1;
        used_pages++;
      end
      is_ready = 1'b1;
    end else if (!is_ready) begin
      r.status = bpa_pkg::ST_NOINIT;
    end else if (f == bpa_pkg::FN_ALLOC) begin
      r.status = bpa_pkg::ST_OOM;
      for (int i = 0; i < page_total; i++) begin
        if (!page_used[i]) begin
          page_used[i] = 1'b1;
          used_pages++;
          r.page_address = i * PG_BYTES;
          r.status = bpa_pkg::ST_OK;
          break;
        end
      end
    end else begin
      p = a / PG_BYTES;
      if ((a % PG_BYTES) != 0 || p >= page_total) begin
        r.status = bpa_pkg::ST_BADADDR;
      end else if (f == bpa_pkg::FN_FREE) begin
        if (page_used[p]) begin
          page_used[p] = 1'b0;
          if (used_pages > 0) used_pages--;
        end
      end else begin
        r.page_free = !page_used[p];
      end
    end
    r.free_pages = 16'(page_total - used_pages);
    r.allocated_pages = 16'(used_pages);
    r.total_memory = 28'(page_total * PG_BYTES);
    r.initialized = is_ready;
    return r;
  endfunction

  task automatic send_request(bpa_pkg::func_t f, logic [31:0] a);
    int gap;
    in_valid <= 1'b1;
    func <= f;
    address <= a;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(predict_alloc(f, a));
    if (!steady_send) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap = $urandom_range(1, 6);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_mem_size(logic [31:0] v);
    wait_drain();
    memory_bytes_we <= 1'b1;
    memory_bytes <= v;
    @(posedge clk);
    mem_size = v;
    memory_bytes_we <= 1'b0;
  endtask

  always @(posedge clk) begin
    alloc_result_t e;
    int hold_cnt;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, page_address %h", $time, page_address);
          failed = 1'b1;
        end else begin
          e = pending_results.pop_front();
          if (page_address !== e.page_address || status !== e.status ||
              page_free !== e.page_free || free_pages !== e.free_pages ||
              allocated_pages !== e.allocated_pages ||
              total_memory !== e.total_memory || initialized !== e.initialized) begin
            $display("%0t: mismatch expected addr %h st %0d pf %0b free %0d alloc %0d tot %h init %0b",
                     $time, e.page_address, e.status, e.page_free, e.free_pages,
                     e.allocated_pages, e.total_memory, e.initialized);
            $display("%0t:          actual addr %h st %0d pf %0b free %0d alloc %0d tot %h init %0b",
                     $time, page_address, status, page_free, free_pages,
                     allocated_pages, total_memory, initialized);
            failed = 1'b1;
          end
        end
      end
      if (hold_req) begin
        hold_cnt++;
        if (hold_cnt >= 300) begin
          hold_req = 1'b0;
          hold_cnt = 0;
        end
        out_stall <= 1'b1;
      end else if (steady_recv) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 3) == 0);
      end
    end
  end

  task automatic test_uninitialized();
    send_request(bpa_pkg::FN_ALLOC, 32'h0);
    send_request(bpa_pkg::FN_FREE, 32'h0020_0000);
    send_request(bpa_pkg::FN_QUERY, 32'h0);
    send_request(bpa_pkg::FN_QUERY, 32'hFFFF_FFFF);
  endtask

  task automatic test_small_sizes();
    write_mem_size(32'd0);
    send_request(bpa_pkg::FN_INIT, 32'h0);
    send_request(bpa_pkg::FN_ALLOC, 32'h0);
    send_request(bpa_pkg::FN_QUERY, 32'h0);
    write_mem_size(32'd1);
    send_request(bpa_pkg::FN_INIT, 32'h0);
    send_request(bpa_pkg::FN_ALLOC, 32'h0);
    send_request(bpa_pkg::FN_QUERY, 32'h0);
  endtask

  task automatic test_one_spare_page();
    write_mem_size(32'h0020_0001);
    send_request(bpa_pkg::FN_INIT, 32'h0);
    send_request(bpa_pkg::FN_ALLOC, 32'h0);
    send_request(bpa_pkg::FN_ALLOC, 32'h0);
    send_request(bpa_pkg::FN_FREE, 32'h0020_0000);
    send_request(bpa_pkg::FN_FREE, 32'h0020_0000);
    send_request(bpa_pkg::FN_FREE, 32'h0020_0800);
    send_request(bpa_pkg::FN_QUERY, 32'h0020_0000);
    send_request(bpa_pkg::FN_QUERY, 32'h0020_1000);
    send_request(bpa_pkg::FN_FREE, 32'h0000_5000);
    send_request(bpa_pkg::FN_ALLOC, 32'h0);
    send_request(bpa_pkg::FN_INIT, 32'h0);
    send_request(bpa_pkg::FN_QUERY, 32'h0000_5000);
  endtask

  task automatic test_max_size();
    write_mem_size(32'hFFFF_FFFF);
    send_request(bpa_pkg::FN_INIT, 32'h0);
    send_request(bpa_pkg::FN_ALLOC, 32'h0);
    send_request(bpa_pkg::FN_QUERY, 32'h07FF_F000);
    send_request(bpa_pkg::FN_QUERY, 32'h0800_0000);
    send_request(bpa_pkg::FN_FREE, 32'hFFFF_F000);
  endtask

  task automatic random_phase(logic [31:0] msize, int count);
    int unsigned pick;
    int unsigned pg;
    write_mem_size(msize);
    send_request(bpa_pkg::FN_INIT, $urandom());
    repeat (count) begin
      pick = $urandom_range(0, 99);
      pg = $urandom_range(RSV_PAGES - 8, page_total + 2);
      if (pick < 45)      send_request(bpa_pkg::FN_ALLOC, $urandom());
      else if (pick < 70) send_request(bpa_pkg::FN_FREE, pg * PG_BYTES);
      else if (pick < 88) send_request(bpa_pkg::FN_QUERY, pg * PG_BYTES);
      else if (pick < 92) send_request(bpa_pkg::FN_QUERY,
                                       $urandom_range(0, page_total) * PG_BYTES);
      else if (pick < 98) send_request(bpa_pkg::func_t'($urandom_range(0, 3)),
                                       $urandom());
      else                send_request(bpa_pkg::FN_INIT, $urandom());
    end
  endtask

  task automatic test_random();
    random_phase(32'hFFFF_FFFF, 40);
    for (int k = 0; k < 6; k++) begin
      steady_send = (k == 2);
      steady_recv = (k == 2);
      random_phase($urandom_range(RSV_PAGES + 1, RSV_PAGES + 80) * PG_BYTES
                   - $urandom_range(0, PG_BYTES - 1), 55);
    end
    steady_send = 1'b0;
    steady_recv = 1'b0;
  endtask

  task automatic test_backpressure();
    write_mem_size(32'h0030_0000);
    send_request(bpa_pkg::FN_INIT, 32'h0);
    wait_drain();
    hold_req = 1'b1;
    steady_send = 1'b1;
    repeat (20) send_request(bpa_pkg::FN_ALLOC, 32'h0);
    steady_send = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    memory_bytes_we = 1'b0;
    memory_bytes = '0;
    in_valid = 1'b0;
    func = bpa_pkg::FN_INIT;
    address = '0;
    out_stall = 1'b0;
    failed = 1'b0;
    steady_send = 1'b0;
    steady_recv = 1'b0;
    hold_req = 1'b0;
    burst_left = 0;
    page_used = '0;
    used_pages = 0;
    page_total = 0;
    is_ready = 1'b0;
    mem_size = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_uninitialized();
    test_small_sizes();
    test_one_spare_page();
    test_max_size();
    test_backpressure();
    test_random();
    wait_drain();
    repeat (600) @(posedge clk);
    if (!failed && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire

[filelist.f]
src/bpa_pkg.sv
src/bpa_front.sv
src/bpa_queue.sv
src/bpa_back.sv
src/bitmap_page_allocator.sv
tb/tb_bitmap_page_allocator.sv
